// ===== rtl/core/bounded_ordered_list_engine_unit_macros.svh =====
// Assertion macros for the bounded ordered list engine.
// Each macro assumes clk and arst_n in the scope of use.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BOLE_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BOLE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BOLE_ASSERT(label, ante, cons, msg)
`define BOLE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bole_pkg.sv =====
// Package for the bounded ordered list engine: sizes, codes and result type.
// No dependencies.
`timescale 1ns / 1ps
package bole_pkg;
	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int DUMP_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int OP_W        = 3;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int POS_W       = 5;
	localparam int COUNT_W     = 6;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_HEAD = 3'd0,
		OP_ADD_TAIL = 3'd1,
		OP_DEL_HEAD = 3'd2,
		OP_DEL_VAL  = 3'd3,
		OP_SEARCH   = 3'd4,
		OP_DUMP     = 3'd5,
		OP_CLEAR    = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		status_t                    status;
		logic [POS_W-1:0]           position;
		logic signed [VALUE_W-1:0]  element;
		logic                       element_valid;
		logic [COUNT_W-1:0]         count;
		logic                       last;
	} res_t;
endpackage

// ===== rtl/core/bole_if.sv =====
// Handshake channels of the list engine: request and response.
// Depends on bole_pkg.
`timescale 1ns / 1ps
interface bole_in_if import bole_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [VALUE_W-1:0] item_value;

	modport source (output valid, output op, output item_value, input ready);
	modport sink (input valid, input op, input item_value, output ready);
endinterface

interface bole_out_if import bole_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] element;
	logic                      element_valid;
	logic [COUNT_W-1:0]        count;
	logic                      last;

	modport source (output valid, output status, output position, output element,
		output element_valid, output count, output last, input ready);
	modport sink (input valid, input status, input position, input element,
		input element_valid, input count, input last, output ready);
endinterface

// ===== rtl/core/bounded_ordered_list_engine_unit.sv =====
// Bounded ordered list engine: element RAM, sequencer and response register.
// Insert, delete head, clear and unused codes go from accept through the exec and response states;
// search and delete by value scan from the head, delete by value then closes up the list behind the match.
// Dump: elements leave one per cycle while the response register is free, at most DUMP_MAX of them.
// One transaction at a time: the next request is accepted only once the sequencer is idle again.
// Reset clears head and count; the element RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_unit_macros.svh"
module bounded_ordered_list_engine_unit import bole_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bole_in_if.sink   req,
	bole_out_if.source rsp
);
	res_t                      res;
	res_t                      rsp_q;
	logic                      res_valid;
	logic                      rsp_valid_q;
	logic                      out_free;
	logic                      ram_we;
	logic                      ram_re;
	ptr_t                      ram_waddr;
	ptr_t                      ram_raddr;
	logic signed [VALUE_W-1:0] ram_wdata;
	logic signed [VALUE_W-1:0] ram_rdata;

	assign out_free = !rsp_valid_q || rsp.ready;

	bole_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.out_free  (out_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bole_ram #(
		.DATA_W (VALUE_W),
		.WORDS  (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.position      = rsp_q.position;
	assign rsp.element       = rsp_q.element;
	assign rsp.element_valid = rsp_q.element_valid;
	assign rsp.count         = rsp_q.count;
	assign rsp.last          = rsp_q.last;

	`BOLE_ASSERT(a_res_slot, res_valid, out_free, "result issued into a busy response register")
	`BOLE_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	`BOLE_ASSERT(a_dump_ok, rsp.valid && rsp.element_valid, rsp.status == ST_OK, "dump not ok")
	`BOLE_ASSERT(a_full_cnt, rsp.valid && rsp.status == ST_FULL, rsp.count == COUNT_W'(DEPTH), "full mismatch")
endmodule

// ===== rtl/core/bole_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bole_ram #(
	parameter int DATA_W = 32,
	parameter int WORDS  = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(WORDS)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/bole_seq.sv =====
// Operation sequencer: head and count registers, scan, close-up and dump walks
// over the element RAM. Depends on bole_pkg and bole_if.
`timescale 1ns / 1ps
module bole_seq import bole_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	bole_in_if.sink                   req,
	output res_t                      res,
	output logic                      res_valid,
	input  logic                      out_free,
	output logic                      ram_we,
	output ptr_t                      ram_waddr,
	output logic signed [VALUE_W-1:0] ram_wdata,
	output logic                      ram_re,
	output ptr_t                      ram_raddr,
	input  logic signed [VALUE_W-1:0] ram_rdata
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_DUMP,
		S_RESP
	} state_t;

	state_t                    state_q;
	op_t                       op_q;
	logic signed [VALUE_W-1:0] value_q;
	ptr_t                      head_q;
	cnt_t                      count_q;
	cnt_t                      idx_q;
	status_t                   st_q;
	logic [POS_W-1:0]          pos_q;

	logic full, empty, found, more, dump_last;
	cnt_t idx_nxt;
	ptr_t head_dec;

	// circular index: (head + i + k) mod DEPTH
	function automatic ptr_t phys(input ptr_t hd, input cnt_t i, input logic [1:0] k);
		logic [PTR_W+1:0] s;
		s = (PTR_W+2)'(hd) + (PTR_W+2)'(i) + (PTR_W+2)'(k);
		if (s >= (PTR_W+2)'(DEPTH)) s = s - (PTR_W+2)'(DEPTH);
		if (s >= (PTR_W+2)'(DEPTH)) s = s - (PTR_W+2)'(DEPTH);
		return PTR_W'(s);
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign found     = (ram_rdata == value_q);
	assign idx_nxt   = idx_q + cnt_t'(1);
	assign more      = (idx_nxt < count_q);
	assign dump_last = (idx_nxt == ((count_q > cnt_t'(DUMP_MAX)) ? cnt_t'(DUMP_MAX) : count_q));
	assign head_dec  = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - ptr_t'(1);

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		ram_we            = 1'b0;
		ram_waddr         = head_dec;
		ram_wdata         = value_q;
		ram_re            = 1'b0;
		ram_raddr         = phys(head_q, idx_q, 2'd1);
		res_valid         = 1'b0;
		res.status        = st_q;
		res.position      = pos_q;
		res.element       = '0;
		res.element_valid = 1'b0;
		res.count         = COUNT_W'(count_q);
		res.last          = 1'b1;
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_ADD_HEAD: begin
						ram_we = !full;
					end
					OP_ADD_TAIL: begin
						ram_we    = !full;
						ram_waddr = phys(head_q, count_q, 2'd0);
					end
					OP_DEL_VAL, OP_SEARCH, OP_DUMP: begin
						ram_re    = !empty;
						ram_raddr = phys(head_q, '0, 2'd0);
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				ram_re = 1'b1;
			end
			S_SHIFT: begin
				ram_re    = 1'b1;
				ram_raddr = phys(head_q, idx_q, 2'd2);
				ram_we    = more;
				ram_waddr = phys(head_q, idx_q, 2'd0);
				ram_wdata = ram_rdata;
			end
			S_DUMP: begin
				res_valid         = out_free;
				res.status        = ST_OK;
				res.position      = '0;
				res.element       = ram_rdata;
				res.element_valid = 1'b1;
				res.last          = dump_last;
				ram_re            = out_free && !dump_last;
			end
			S_RESP: begin
				res_valid = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_CLEAR;
			value_q <= '0;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			st_q    <= ST_OK;
			pos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= op_t'(req.op);
						value_q <= req.item_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q    <= ST_OK;
					pos_q   <= '0;
					idx_q   <= '0;
					state_q <= S_RESP;
					case (op_q)
						OP_ADD_HEAD: begin
							if (full) begin
								st_q <= ST_FULL;
							end else begin
								head_q  <= head_dec;
								count_q <= count_q + cnt_t'(1);
							end
						end
						OP_ADD_TAIL: begin
							if (full) begin
								st_q <= ST_FULL;
							end else begin
								count_q <= count_q + cnt_t'(1);
							end
						end
						OP_DEL_HEAD: begin
							if (empty) begin
								st_q <= ST_EMPTY;
							end else begin
								head_q  <= phys(head_q, '0, 2'd1);
								count_q <= count_q - cnt_t'(1);
							end
						end
						OP_DEL_VAL, OP_SEARCH: begin
							if (empty) begin
								st_q <= ST_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_DUMP: begin
							if (empty) begin
								st_q <= ST_EMPTY;
							end else begin
								state_q <= S_DUMP;
							end
						end
						OP_CLEAR: begin
							head_q  <= '0;
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (found) begin
						if (op_q == OP_DEL_VAL) begin
							state_q <= S_SHIFT;
						end else begin
							pos_q   <= POS_W'(idx_q);
							state_q <= S_RESP;
						end
					end else if (more) begin
						idx_q <= idx_nxt;
					end else begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_RESP;
					end
				end
				S_SHIFT: begin
					if (more) begin
						idx_q <= idx_nxt;
					end else begin
						count_q <= count_q - cnt_t'(1);
						state_q <= S_RESP;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_nxt;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== sim/bounded_ordered_list_engine_unit_tb.sv =====
// Self-checking testbench for the bounded ordered list engine.
// Random insert/delete/search/dump traffic against a list predictor, with random backpressure.
// Depends on bole_pkg, bole_if.sv and bounded_ordered_list_engine_unit.
`timescale 1ns / 1ps
module bounded_ordered_list_engine_unit_tb;
	import bole_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 170;
	localparam int HOLD_AT      = 900;
	localparam int HOLD_LEN     = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 2 * DEPTH + 8;

	typedef enum {EP_GROW, EP_SHRINK, EP_MIXED, EP_FILL} episode_t;

	class list_scoreboard;
		logic signed [VALUE_W-1:0] words [DEPTH];
		int unsigned head = 0;
		int unsigned fill = 0;
		res_t expected_results[$];
		int errors = 0;

		function void push_res(status_t st, int pos, logic signed [VALUE_W-1:0] el,
			logic ev, logic lst);
			res_t r;
			r.status        = st;
			r.position      = POS_W'(pos);
			r.element       = el;
			r.element_valid = ev;
			r.count         = COUNT_W'(fill);
			r.last          = lst;
			expected_results = {expected_results, r};
		endfunction

		function int find_first(logic signed [VALUE_W-1:0] v);
			for (int i = 0; i < fill; i++)
				if (words[(head + i) % DEPTH] === v)
					return i;
			return fill;
		endfunction

		function void predict_list_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] v);
			int n;
			int lim;
			case (op)
				OP_ADD_HEAD: begin
					if (fill >= DEPTH) begin
						push_res(ST_FULL, 0, 0, 1'b0, 1'b1);
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						words[head] = v;
						fill++;
						push_res(ST_OK, 0, 0, 1'b0, 1'b1);
					end
				end
				OP_ADD_TAIL: begin
					if (fill >= DEPTH) begin
						push_res(ST_FULL, 0, 0, 1'b0, 1'b1);
					end else begin
						words[(head + fill) % DEPTH] = v;
						fill++;
						push_res(ST_OK, 0, 0, 1'b0, 1'b1);
					end
				end
				OP_DEL_HEAD: begin
					if (fill == 0) begin
						push_res(ST_EMPTY, 0, 0, 1'b0, 1'b1);
					end else begin
						head = (head + 1) % DEPTH;
						fill--;
						push_res(ST_OK, 0, 0, 1'b0, 1'b1);
					end
				end
				OP_DEL_VAL: begin
					n = find_first(v);
					if (fill == 0) begin
						push_res(ST_EMPTY, 0, 0, 1'b0, 1'b1);
					end else if (n >= fill) begin
						push_res(ST_NOTFOUND, 0, 0, 1'b0, 1'b1);
					end else begin
						for (int i = n; i + 1 < fill; i++)
							words[(head + i) % DEPTH] = words[(head + i + 1) % DEPTH];
						fill--;
						push_res(ST_OK, 0, 0, 1'b0, 1'b1);
					end
				end
				OP_SEARCH: begin
					n = find_first(v);
					if (fill == 0)
						push_res(ST_EMPTY, 0, 0, 1'b0, 1'b1);
					else if (n >= fill)
						push_res(ST_NOTFOUND, 0, 0, 1'b0, 1'b1);
					else
						push_res(ST_OK, n, 0, 1'b0, 1'b1);
				end
				OP_DUMP: begin
					if (fill == 0) begin
						push_res(ST_EMPTY, 0, 0, 1'b0, 1'b1);
					end else begin
						lim = (fill < MAX_RESULTS) ? fill : MAX_RESULTS;
						for (int i = 0; i < lim; i++)
							push_res(ST_OK, 0, words[(head + i) % DEPTH], 1'b1, i + 1 == lim);
					end
				end
				OP_CLEAR: begin
					head = 0;
					fill = 0;
					push_res(ST_OK, 0, 0, 1'b0, 1'b1);
				end
				default: begin
					push_res(ST_OK, 0, 0, 1'b0, 1'b1);
				end
			endcase
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d element %0h count %0d",
					got.status, got.element, got.count);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			cmp_field("status", want.status, got.status);
			cmp_field("position", want.position, got.position);
			cmp_field("element", want.element, got.element);
			cmp_field("element_valid", want.element_valid, got.element_valid);
			cmp_field("count", want.count, got.count);
			cmp_field("last", want.last, got.last);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bole_in_if  req_ch();
	bole_out_if rsp_ch();

	bounded_ordered_list_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_scoreboard sb = new;
	logic signed [VALUE_W-1:0] pool [8];
	int burst_left;
	int idle_cycles = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin : monitor
		res_t got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.predict_list_op(req_ch.op, req_ch.item_value);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status        = status_t'(rsp_ch.status);
				got.position      = rsp_ch.position;
				got.element       = rsp_ch.element;
				got.element_valid = rsp_ch.element_valid;
				got.count         = rsp_ch.count;
				got.last          = rsp_ch.last;
				sb.check_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("bounded_ordered_list_engine_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: rotating stall patterns plus one long hold
	initial begin : receiver
		int cyc;
		int mode_left;
		int rmode;
		rsp_ch.ready = 1'b0;
		cyc = 0;
		mode_left = 0;
		rmode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == HOLD_AT) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					rmode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (rmode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
					default: rsp_ch.ready <= ((cyc % 8) >= 3);
				endcase
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.item_value <= v;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic pace(input bit steady);
		if (!steady) begin
			if (burst_left == 0) begin
				idle($urandom_range(1, 6));
				burst_left = $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		idle(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [OP_W-1:0] pick_op(episode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			EP_GROW: begin
				if (r < 35) return OP_ADD_HEAD;
				if (r < 70) return OP_ADD_TAIL;
				if (r < 80) return OP_SEARCH;
				if (r < 90) return OP_DEL_VAL;
				if (r < 95) return OP_DUMP;
			end
			EP_SHRINK: begin
				if (r < 35) return OP_DEL_HEAD;
				if (r < 70) return OP_DEL_VAL;
				if (r < 85) return OP_SEARCH;
				if (r < 90) return OP_DUMP;
				if (r < 95) return OP_ADD_TAIL;
			end
			default: ;
		endcase
		return OP_W'($urandom_range(0, 7));
	endfunction

	initial begin : stimulus
		episode_t mode;
		bit steady;
		int len;
		int rand_sent;
		int ep;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_CLEAR;
		req_ch.item_value = '0;
		burst_left        = 0;
		pool[0] = 32'sh8000_0000;
		pool[1] = 32'sh7fff_ffff;
		pool[2] = 32'sh0000_0000;
		pool[3] = -32'sd1;
		for (int i = 4; i < 8; i++)
			pool[i] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list corner cases, then extremes and close-up
		send_item(OP_DEL_HEAD, 32'sd5);
		send_item(OP_DEL_VAL, 32'sd5);
		send_item(OP_SEARCH, 32'sd5);
		send_item(OP_DUMP, 32'sd0);
		send_item(OP_UNUSED, 32'sd0);
		send_item(OP_CLEAR, 32'sd0);
		pace(1'b0);
		send_item(OP_ADD_HEAD, 32'sh7fff_ffff);
		send_item(OP_ADD_TAIL, 32'sh8000_0000);
		send_item(OP_ADD_HEAD, 32'sh0000_0000);
		send_item(OP_ADD_TAIL, -32'sd1);
		send_item(OP_SEARCH, 32'sh8000_0000);
		send_item(OP_SEARCH, 32'sd12345);
		pace(1'b0);
		send_item(OP_DUMP, 32'sd0);
		send_item(OP_DEL_VAL, 32'sh7fff_ffff);
		send_item(OP_DEL_VAL, 32'sd999);
		send_item(OP_DEL_VAL, -32'sd1);
		send_item(OP_DEL_HEAD, 32'sd0);
		send_item(OP_UNUSED, 32'sh5555_5555);
		send_item(OP_ADD_TAIL, 32'sh5555_5555);
		send_item(OP_ADD_HEAD, 32'shaaaa_aaaa);
		send_item(OP_SEARCH, 32'sh5555_5555);
		send_item(OP_DUMP, 32'sd0);
		send_item(OP_CLEAR, 32'sd0);
		send_item(OP_DUMP, 32'sd0);
		wait_drained();

		rand_sent = 0;
		ep = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			mode = (ep == 0) ? EP_FILL : episode_t'($urandom_range(0, 3));
			steady = ($urandom_range(0, 3) == 0);
			len = (mode == EP_FILL) ? DEPTH + 3 : $urandom_range(8, 24);
			for (int k = 0; k < len; k++) begin
				if (mode == EP_FILL)
					send_item($urandom_range(0, 1) ? OP_ADD_HEAD : OP_ADD_TAIL, pick_value());
				else
					send_item(pick_op(mode), pick_value());
				rand_sent++;
				pace(steady);
			end
			if (mode == EP_FILL) begin
				send_item(OP_DUMP, pick_value());
				pace(steady);
				send_item(OP_SEARCH, pick_value());
				pace(steady);
				rand_sent += 2;
			end
			if (ep == 0 || $urandom_range(0, 2) == 0)
				wait_drained();
			ep++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("bounded_ordered_list_engine_unit regression: pass");
		end else begin
			$display("bounded_ordered_list_engine_unit regression: fail");
		end
		$finish;
	end
endmodule
